[rtl/gasp_pkg.sv]
`default_nettype none

package gasp_pkg;

  localparam int FUNC_W   = 2;
  localparam int DIM_W    = 12;
  localparam int SEL_W    = 4;
  localparam int LIMIT_W  = 5;
  localparam int PAGE_W   = 4;
  localparam int ORIGIN_W = 11;
  localparam int EDGE_W   = 12;
  localparam int COORD_W  = 12;
  localparam int SUM_W    = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PLACE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_MARK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic latch;
    logic search;
    logic open;
    logic commit;
    logic read;
    logic mark;
    logic emit;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  oversize;
    logic  hit;
    logic  last;
    logic  open_ok;
    logic  out_busy;
  } stat_t;

endpackage

`default_nettype wire

[rtl/gasp_req_if.sv]
`default_nettype none

interface gasp_req_if;
  import gasp_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [DIM_W-1:0]   glyph_width;
  logic [DIM_W-1:0]   glyph_height;
  logic [SEL_W-1:0]   page_select;

  modport source (
    output valid, func, glyph_width, glyph_height, page_select,
    input  ready
  );

  modport sink (
    input  valid, func, glyph_width, glyph_height, page_select,
    output ready
  );
endinterface

`default_nettype wire

[rtl/gasp_rsp_if.sv]
`default_nettype none

interface gasp_rsp_if;
  import gasp_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [PAGE_W-1:0]   page_index;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic                dirty_valid;
  logic [EDGE_W-1:0]   dirty_left;
  logic [EDGE_W-1:0]   dirty_top;
  logic [EDGE_W-1:0]   dirty_right;
  logic [EDGE_W-1:0]   dirty_bottom;

  modport source (
    output valid, ok, page_index, origin_x, origin_y, dirty_valid,
           dirty_left, dirty_top, dirty_right, dirty_bottom,
    input  ready
  );

  modport sink (
    input  valid, ok, page_index, origin_x, origin_y, dirty_valid,
           dirty_left, dirty_top, dirty_right, dirty_bottom,
    output ready
  );
endinterface

`default_nettype wire

[rtl/gasp_ctrl.sv]
`default_nettype none

module gasp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gasp_pkg::stat_t stat,
  output gasp_pkg::cmd_t  cmd
);
  import gasp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_OPEN,
    S_COMMIT,
    S_READ,
    S_MARK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.func)
          FUNC_PLACE: state_next = stat.oversize ? S_EMIT : S_SEARCH;
          FUNC_READ:  state_next = S_READ;
          FUNC_MARK:  state_next = S_MARK;
          default:    state_next = S_EMIT;
        endcase
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.hit) begin
          state_next = S_COMMIT;
        end else if (stat.last) begin
          state_next = S_OPEN;
        end
      end
      S_OPEN: begin
        cmd.open   = 1'b1;
        state_next = stat.open_ok ? S_COMMIT : S_EMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EMIT;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EMIT;
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (stat.last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

[rtl/gasp_dp.sv]
`default_nettype none

module gasp_dp #(
  parameter int PAGE_SIZE = 2048,
  parameter int MAX_PAGES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gasp_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  logic [gasp_pkg::FUNC_W-1:0]     in_func,
  input  logic [gasp_pkg::DIM_W-1:0]      in_width,
  input  logic [gasp_pkg::DIM_W-1:0]      in_height,
  input  logic [gasp_pkg::SEL_W-1:0]      in_select,
  input  gasp_pkg::cmd_t                  cmd,
  output gasp_pkg::stat_t                 stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [gasp_pkg::PAGE_W-1:0]     out_page,
  output logic [gasp_pkg::ORIGIN_W-1:0]   out_x,
  output logic [gasp_pkg::ORIGIN_W-1:0]   out_y,
  output logic                            out_dirty,
  output logic [gasp_pkg::EDGE_W-1:0]     out_left,
  output logic [gasp_pkg::EDGE_W-1:0]     out_top,
  output logic [gasp_pkg::EDGE_W-1:0]     out_right,
  output logic [gasp_pkg::EDGE_W-1:0]     out_bottom
);
  import gasp_pkg::*;

  localparam int NPAGES = (MAX_PAGES < (1 << PAGE_W)) ? MAX_PAGES : (1 << PAGE_W);
  localparam int IW     = (NPAGES > 1) ? $clog2(NPAGES) : 1;
  localparam int CNTW   = $clog2(NPAGES + 1);
  localparam int SELCW  = SEL_W + CNTW;

  localparam logic [SUM_W-1:0]   FIT_LIM    = SUM_W'(PAGE_SIZE - 1);
  localparam logic [SUM_W-1:0]   DIM_MAX    = SUM_W'(PAGE_SIZE - 2);
  localparam logic [SUM_W-1:0]   RIGHT_FULL = SUM_W'(PAGE_SIZE);
  localparam logic [SUM_W-1:0]   ONE        = SUM_W'(1);
  localparam logic [SUM_W-1:0]   EDGE_MAX   = SUM_W'((1 << EDGE_W) - 1);
  localparam logic [LIMIT_W-1:0] NPAGES_L   = LIMIT_W'(NPAGES);

  logic [LIMIT_W-1:0] page_limit;
  logic [CNTW-1:0]    pages_open;
  logic [CNTW-1:0]    p;
  func_t              func;
  logic [DIM_W-1:0]   w;
  logic [DIM_W-1:0]   h;
  logic [SEL_W-1:0]   sel;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;

  logic [COORD_W-1:0] pen_col   [NPAGES];
  logic [COORD_W-1:0] pen_row   [NPAGES];
  logic [COORD_W-1:0] shelf     [NPAGES];
  logic               flag      [NPAGES];
  logic [COORD_W-1:0] rect_left [NPAGES];
  logic [COORD_W-1:0] rect_top  [NPAGES];
  logic [SUM_W-1:0]   rect_right[NPAGES];
  logic [COORD_W-1:0] rect_bot  [NPAGES];

  logic                res_ok;
  logic [PAGE_W-1:0]   res_page;
  logic [ORIGIN_W-1:0] res_x;
  logic [ORIGIN_W-1:0] res_y;
  logic                res_dirty;
  logic [EDGE_W-1:0]   res_left;
  logic [EDGE_W-1:0]   res_top;
  logic [EDGE_W-1:0]   res_right;
  logic [EDGE_W-1:0]   res_bottom;

  logic [IW-1:0]      idx;
  logic [COORD_W-1:0] cur_pc;
  logic [COORD_W-1:0] cur_pr;
  logic [COORD_W-1:0] cur_sb;
  logic               cur_flag;
  logic [SUM_W-1:0]   w_ext;
  logic [SUM_W-1:0]   h_ext;
  logic [SUM_W-1:0]   sb1;
  logic [SUM_W-1:0]   ny;
  logic               fit1;
  logic               fit2;
  logic               w_fit;
  logic               fit11;
  logic [LIMIT_W-1:0] cap_l;
  logic [CNTW-1:0]    cap;
  logic               room;
  logic [CNTW:0]      p_inc;
  logic               last;
  logic               sel_ok;
  logic [SUM_W-1:0]   xw1;
  logic [SUM_W-1:0]   yh;
  logic [SUM_W-1:0]   yh1;
  logic [COORD_W-1:0] x_m1;
  logic [COORD_W-1:0] y_m1;
  logic [COORD_W-1:0] new_left;
  logic [COORD_W-1:0] new_top;
  logic [SUM_W-1:0]   new_right;
  logic [COORD_W-1:0] new_bot;
  logic [SUM_W-1:0]   shelf_new;

  always_comb begin
    idx      = cmd.read ? sel[IW-1:0] : p[IW-1:0];
    cur_pc   = pen_col[idx];
    cur_pr   = pen_row[idx];
    cur_sb   = shelf[idx];
    cur_flag = flag[idx];

    w_ext = {1'b0, w};
    h_ext = {1'b0, h};
    fit1  = ({1'b0, cur_pc} + w_ext < FIT_LIM) && ({1'b0, cur_pr} + h_ext < FIT_LIM);
    sb1   = {1'b0, cur_sb} + ONE;
    ny    = ({1'b0, cur_pr} > sb1) ? {1'b0, cur_pr} : sb1;
    w_fit = (w_ext + ONE < FIT_LIM);
    fit2  = w_fit && (ny + h_ext < FIT_LIM);
    fit11 = w_fit && (h_ext + ONE < FIT_LIM);

    cap_l  = (page_limit < NPAGES_L) ? page_limit : NPAGES_L;
    cap    = CNTW'(cap_l);
    room   = (pages_open < cap);
    p_inc  = {1'b0, p} + (CNTW + 1)'(1);
    last   = (p_inc >= {1'b0, pages_open});
    sel_ok = (SELCW'(sel) < SELCW'(pages_open));

    xw1  = {1'b0, x} + w_ext + ONE;
    yh   = {1'b0, y} + h_ext;
    yh1  = yh + ONE;
    x_m1 = x - COORD_W'(1);
    y_m1 = y - COORD_W'(1);

    if (cur_flag) begin
      new_left  = (rect_left[idx] < x_m1) ? rect_left[idx] : x_m1;
      new_top   = (rect_top[idx] < y_m1) ? rect_top[idx] : y_m1;
      new_right = (rect_right[idx] > xw1) ? rect_right[idx] : xw1;
      new_bot   = ({1'b0, rect_bot[idx]} > yh1) ? rect_bot[idx] : yh1[COORD_W-1:0];
    end else begin
      new_left  = x_m1;
      new_top   = y_m1;
      new_right = xw1;
      new_bot   = yh1[COORD_W-1:0];
    end
    shelf_new = ({1'b0, cur_sb} > yh) ? {1'b0, cur_sb} : yh;

    stat.func     = func;
    stat.oversize = (w_ext > DIM_MAX) || (h_ext > DIM_MAX);
    stat.hit      = fit1 || fit2;
    stat.last     = last;
    stat.open_ok  = room && fit11;
    stat.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= LIMIT_RESET;
      pages_open <= CNTW'(1);
      out_valid  <= 1'b0;
      for (int i = 0; i < NPAGES; i++) begin
        pen_col[i] <= COORD_W'(1);
        pen_row[i] <= COORD_W'(1);
        shelf[i]   <= '0;
        flag[i]    <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        page_limit <= cfg_wr_data;
      end
      if (cmd.open && room) begin
        pages_open <= fit11 ? pages_open + CNTW'(1) : cap;
      end
      if (cmd.commit) begin
        pen_col[idx] <= xw1[COORD_W-1:0];
        pen_row[idx] <= y;
        shelf[idx]   <= shelf_new[COORD_W-1:0];
        flag[idx]    <= 1'b1;
      end
      if (cmd.read && sel_ok) begin
        flag[idx] <= 1'b0;
      end
      if (cmd.mark) begin
        flag[idx] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func       <= func_t'(in_func);
      w          <= in_width;
      h          <= in_height;
      sel        <= in_select;
      p          <= '0;
      res_ok     <= 1'b0;
      res_page   <= '0;
      res_x      <= '0;
      res_y      <= '0;
      res_dirty  <= 1'b0;
      res_left   <= '0;
      res_top    <= '0;
      res_right  <= '0;
      res_bottom <= '0;
    end
    if (cmd.search) begin
      if (fit1 || fit2) begin
        x <= fit1 ? cur_pc : COORD_W'(1);
        y <= fit1 ? cur_pr : ny[COORD_W-1:0];
      end else begin
        p <= p_inc[CNTW-1:0];
      end
    end
    if (cmd.open && room && fit11) begin
      p <= pages_open;
      x <= COORD_W'(1);
      y <= COORD_W'(1);
    end
    if (cmd.commit) begin
      rect_left[idx]  <= new_left;
      rect_top[idx]   <= new_top;
      rect_right[idx] <= new_right;
      rect_bot[idx]   <= new_bot;
      res_ok          <= 1'b1;
      res_page        <= PAGE_W'(p);
      res_x           <= x[ORIGIN_W-1:0];
      res_y           <= y[ORIGIN_W-1:0];
    end
    if (cmd.read) begin
      res_ok <= sel_ok;
      if (sel_ok && cur_flag) begin
        res_dirty  <= 1'b1;
        res_left   <= rect_left[idx];
        res_top    <= rect_top[idx];
        res_right  <= (rect_right[idx] > EDGE_MAX) ? EDGE_MAX[EDGE_W-1:0]
                                                   : rect_right[idx][EDGE_W-1:0];
        res_bottom <= rect_bot[idx];
      end
    end
    if (cmd.mark) begin
      rect_left[idx]  <= '0;
      rect_top[idx]   <= '0;
      rect_right[idx] <= RIGHT_FULL;
      rect_bot[idx]   <= sb1[COORD_W-1:0];
      res_ok          <= 1'b1;
      if (!last) begin
        p <= p_inc[CNTW-1:0];
      end
    end
    if (cmd.emit) begin
      out_ok     <= res_ok;
      out_page   <= res_page;
      out_x      <= res_x;
      out_y      <= res_y;
      out_dirty  <= res_dirty;
      out_left   <= res_left;
      out_top    <= res_top;
      out_right  <= res_right;
      out_bottom <= res_bottom;
    end
  end

endmodule

`default_nettype wire

[rtl/glyph_atlas_shelf_packer.sv]
// Shelf allocator for square glyph atlas pages with a one-pixel gutter.
// Requests arrive on the req channel and each one yields exactly one result
// transfer on the rsp channel, in order. The user must write the page limit
// register through cfg_wr_en and cfg_wr_data only while the block is idle;
// the block itself does not enforce this. A place request searches the
// open pages one per cycle, starting at page 0. The first page that fits
// takes the glyph; when none fits, a new page is opened if the page limit
// allows and the glyph fits an empty page, and otherwise the place fails.
// A read-and-clear request reads and clears the selected page's dirty
// rectangle, a mark-all request marks every open page dirty, and an
// oversized glyph or unused code goes straight to the result.
// One request is in work at a time; req.ready rises at the same clock edge
// at which the result is loaded into the output register.
// Reset leaves one page open and empty, every page clean and a page limit
// of 16. When the receiver stalls, the result holds in the output register
// while the next request is still taken and worked on; that request then
// waits for the output register before its own result is loaded.
`default_nettype none

module glyph_atlas_shelf_packer #(
  parameter int PAGE_SIZE = 2048,
  parameter int MAX_PAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  gasp_req_if.sink                     req,
  gasp_rsp_if.source                   rsp,
  input  logic                         cfg_wr_en,
  input  logic [gasp_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import gasp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gasp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gasp_dp #(
    .PAGE_SIZE (PAGE_SIZE),
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_func     (req.func),
    .in_width    (req.glyph_width),
    .in_height   (req.glyph_height),
    .in_select   (req.page_select),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_ok      (rsp.ok),
    .out_page    (rsp.page_index),
    .out_x       (rsp.origin_x),
    .out_y       (rsp.origin_y),
    .out_dirty   (rsp.dirty_valid),
    .out_left    (rsp.dirty_left),
    .out_top     (rsp.dirty_top),
    .out_right   (rsp.dirty_right),
    .out_bottom  (rsp.dirty_bottom)
  );

endmodule

`default_nettype wire
